// File: rtl/via_pkg.sv
// ----------------------------------------------------------------------------
// via_pkg: shared types and constants of the virtual inertia admittance block
// Register indexes, sequencer states and fixed field widths.
// ----------------------------------------------------------------------------
package via_pkg;

  // sample rate register width, fixed by the register map
  localparam int RateW   = 20;
  // configuration register index width
  localparam int CfgIdxW = 3;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DAMPING = 3'd0,
    CFG_SPRING  = 3'd1,
    CFG_INERTIA = 3'd2,
    CFG_RATE    = 3'd3,
    CFG_VLIMIT  = 3'd4,
    CFG_BAND    = 3'd5
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_MUL,
    ST_SCALE,
    ST_NUM,
    ST_ACC_START,
    ST_DIV_ACC,
    ST_SUM,
    ST_DIV_DLT,
    ST_STEP,
    ST_CLAMP,
    ST_OUT
  } via_state_e;

endpackage

// File: rtl/via_serial_mul.sv
// ----------------------------------------------------------------------------
// via_serial_mul: bit-serial signed multiplier
// Shift-add over the multiplier bits, one bit per cycle, LSB first. The last
// bit carries negative weight and subtracts the multiplicand.
// ----------------------------------------------------------------------------
module via_serial_mul #(
  parameter int AW = 33,
  parameter int BW = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [AW-1:0]    a_i,
  input  logic signed [BW-1:0]    b_i,
  output logic                    done_o,
  output logic signed [AW+BW-1:0] product_o
);

  localparam int CntW = $clog2(BW + 1);

  logic                busy_q;
  logic                done_q;
  logic [CntW-1:0]     cnt_q;
  logic signed [AW-1:0] a_q;
  logic signed [AW:0]   hi_q;
  logic [BW-1:0]        lo_q;

  logic                 last;
  logic signed [AW+1:0] addend;
  logic signed [AW+1:0] sum;

  assign last = (cnt_q == CntW'(1));

  always_comb begin
    if (!lo_q[0]) begin
      addend = '0;
    end else if (last) begin
      addend = -((AW+2)'(a_q));
    end else begin
      addend = (AW+2)'(a_q);
    end
    sum = (AW+2)'(hi_q) + addend;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(BW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CntW'(1);
        if (last) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q  <= a_i;
      hi_q <= '0;
      lo_q <= b_i;
    end else if (busy_q) begin
      // shift the partial product right, low bit drops into lo
      hi_q <= sum[AW+1:1];
      lo_q <= {sum[0], lo_q[BW-1:1]};
    end
  end

  assign done_o    = done_q;
  assign product_o = $signed({hi_q[AW-1:0], lo_q});

endmodule

// File: rtl/via_serial_div.sv
// ----------------------------------------------------------------------------
// via_serial_div: restoring unsigned divider, one quotient bit per cycle
// The dividend is loaded MSB-aligned; when done_o rises the quotient sits
// in the low steps_i bits of quotient_o.
// ----------------------------------------------------------------------------
module via_serial_div #(
  parameter int DW = 48,
  parameter int VW = 31
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [DW-1:0]                dividend_i,
  input  logic [VW-1:0]                divisor_i,
  input  logic [$clog2(DW+1)-1:0]      steps_i,
  output logic                         done_o,
  output logic [DW-1:0]                quotient_o
);

  localparam int CntW = $clog2(DW + 1);

  logic            busy_q;
  logic            done_q;
  logic [CntW-1:0] cnt_q;
  logic [DW-1:0]   q_q;
  logic [VW-1:0]   rem_q;
  logic [VW-1:0]   dvs_q;

  logic [VW:0]     trial;
  logic            ge;
  logic [VW-1:0]   rem_d;
  logic            last;

  assign last  = (cnt_q == CntW'(1));
  assign trial = {rem_q, q_q[DW-1]};
  assign ge    = (trial >= {1'b0, dvs_q});
  assign rem_d = ge ? VW'(trial - {1'b0, dvs_q}) : trial[VW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= steps_i;
      end else if (busy_q) begin
        cnt_q <= cnt_q - CntW'(1);
        if (last) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      q_q   <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      q_q   <= {q_q[DW-2:0], ge};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = q_q;

endmodule

// File: rtl/virtual_inertia_admittance.sv
// ----------------------------------------------------------------------------
// virtual_inertia_admittance: virtual mass-damper-spring reference velocity
//
//   channel  direction  handshake                 payload
//   cfg      in         cfg_valid_i/cfg_ready_o   cfg_index_i, cfg_data_i
//   in       in         in_valid_i/in_stall_o     cmd_i, applied_force_i,
//                                                 measured_velocity_i, position_i
//   out      out        out_valid_o/out_stall_i   virtual_velocity_o, limited_o
//
// One sample at a time: two bit-serial multipliers run side by side, then one
// shared restoring divider runs for the acceleration (skipped when the inertia
// is zero) and then for the velocity step. A clear command zeroes the state
// and skips the arithmetic. Reset clears the state and loads the register
// defaults. The output register holds a result while out_stall_i is high; a
// new sample is taken once the previous result sits in it.
// ----------------------------------------------------------------------------
module virtual_inertia_admittance #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [via_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [((DATA_WIDTH > via_pkg::RateW) ? DATA_WIDTH : via_pkg::RateW)-1:0]
                                              cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                cmd_i,
  input  logic signed [DATA_WIDTH-1:0]        applied_force_i,
  input  logic signed [DATA_WIDTH-1:0]        measured_velocity_i,
  input  logic signed [DATA_WIDTH-1:0]        position_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [DATA_WIDTH-1:0]        virtual_velocity_o,
  output logic                                limited_o
);

  import via_pkg::*;

  localparam int W    = DATA_WIDTH;
  localparam int F    = FRAC_BITS;
  localparam int MAW  = W + 1;
  localparam int PW   = MAW + W;
  localparam int ShW  = PW - F;
  localparam int ExW  = (ShW > W) ? ShW : W + 1;
  localparam int DW   = W + F;
  localparam int DvW  = (W - 1 > RateW + 1) ? W - 1 : RateW + 1;
  localparam int StW  = $clog2(DW + 1);

  localparam logic signed [W-1:0] SMax       = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] SMin       = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-2:0]        InertiaRst = (W-1)'(64'd1 << F);
  localparam logic [RateW-1:0]    RateRst    = RateW'(1000);

  // configuration registers
  logic signed [W-1:0] damping_q;
  logic signed [W-1:0] spring_q;
  logic [W-2:0]        inertia_q;
  logic [RateW-1:0]    rate_q;
  logic [W-2:0]        vlim_q;
  logic [W-2:0]        band_q;

  via_state_e state_q, state_d;

  // sample and intermediate registers
  logic signed [W-1:0] force_q, vel_q, pos_q;
  logic signed [W-1:0] dmp_q, spr_q, num_q;
  logic signed [W-1:0] accel_q, prev_q, vacc_q;
  logic                sum_neg_q;
  logic signed [W:0]   delta_q;
  logic signed [W-1:0] vsat_q;
  logic signed [W-1:0] res_vel_q;
  logic                res_lim_q;
  logic                out_valid_q;
  logic signed [W-1:0] out_vel_q;
  logic                out_lim_q;

  logic                in_accept;
  logic                out_free;
  logic                mul_start;
  logic                div_start;
  logic [DW-1:0]       div_dividend;
  logic [DvW-1:0]      div_divisor;
  logic [StW-1:0]      div_steps;

  logic                dmp_done, spr_done, div_done;
  logic signed [PW-1:0] dmp_prod, spr_prod;
  logic [DW-1:0]       div_q;

  logic [W-1:0]        pos_mag;
  logic signed [W:0]   spr_op;
  logic signed [MAW-1:0] spr_a, dmp_a;
  logic signed [ExW-1:0] dmp_ext, spr_ext;
  logic signed [W+1:0] num_sum;
  logic [W-1:0]        num_mag;
  logic signed [W:0]   sum_s;
  logic [W:0]          sum_mag;
  logic [RateW-1:0]    rate_eff;
  logic [W:0]          dq_mag;
  logic signed [W+1:0] vsum;
  logic signed [W-1:0] lim_s;
  logic signed [W-1:0] neg_lim;

  function automatic logic signed [W-1:0] sat_ext(input logic signed [ExW-1:0] x);
    logic ones;
    logic zeros;
    ones  = &x[ExW-1:W-1];
    zeros = ~|x[ExW-1:W-1];
    if (ones || zeros) begin
      return x[W-1:0];
    end
    return x[ExW-1] ? SMin : SMax;
  endfunction

  function automatic logic signed [W-1:0] sat_w2(input logic signed [W+1:0] x);
    logic ones;
    logic zeros;
    ones  = &x[W+1:W-1];
    zeros = ~|x[W+1:W-1];
    if (ones || zeros) begin
      return x[W-1:0];
    end
    return x[W+1] ? SMin : SMax;
  endfunction

  // --------------------------------------------------------------------------
  // configuration port
  // --------------------------------------------------------------------------
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      damping_q <= '0;
      spring_q  <= '0;
      inertia_q <= InertiaRst;
      rate_q    <= RateRst;
      vlim_q    <= '1;
      band_q    <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_DAMPING: damping_q <= $signed(cfg_data_i[W-1:0]);
        CFG_SPRING:  spring_q  <= $signed(cfg_data_i[W-1:0]);
        CFG_INERTIA: inertia_q <= cfg_data_i[W-2:0];
        CFG_RATE:    rate_q    <= cfg_data_i[RateW-1:0];
        CFG_VLIMIT:  vlim_q    <= cfg_data_i[W-2:0];
        CFG_BAND:    band_q    <= cfg_data_i[W-2:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // datapath combinational terms
  // --------------------------------------------------------------------------
  assign in_accept = in_valid_i && !in_stall_o;
  assign out_free  = !out_valid_q || !out_stall_i;

  // spring operand: distance beyond the dead band, zero inside it
  assign pos_mag = pos_q[W-1] ? $unsigned(-pos_q) : $unsigned(pos_q);
  assign spr_op  = pos_q[W-1] ? ($signed({pos_q[W-1], pos_q}) + $signed({2'b00, band_q}))
                              : ($signed({pos_q[W-1], pos_q}) - $signed({2'b00, band_q}));
  assign spr_a   = (pos_mag <= {1'b0, band_q}) ? '0 : spr_op;
  assign dmp_a   = MAW'(vel_q);

  // floor shift by the fraction bits, then saturate
  assign dmp_ext = ExW'($signed(dmp_prod[PW-1:F]));
  assign spr_ext = ExW'($signed(spr_prod[PW-1:F]));

  assign num_sum = (W+2)'(force_q) - (W+2)'(dmp_q) - (W+2)'(spr_q);
  assign num_mag = num_q[W-1] ? $unsigned(-num_q) : $unsigned(num_q);

  assign sum_s    = (W+1)'(accel_q) + (W+1)'(prev_q);
  assign sum_mag  = sum_s[W] ? $unsigned(-sum_s) : $unsigned(sum_s);
  assign rate_eff = (rate_q == '0) ? RateW'(1) : rate_q;

  assign dq_mag  = div_q[W:0];
  assign vsum    = (W+2)'(vacc_q) + (W+2)'(delta_q);
  assign lim_s   = $signed({1'b0, vlim_q});
  assign neg_lim = -lim_s;

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          state_d = cmd_i ? ST_OUT : ST_PREP;
        end
      end
      ST_PREP:      state_d = ST_MUL;
      ST_MUL: begin
        if (dmp_done) begin
          state_d = ST_SCALE;
        end
      end
      ST_SCALE:     state_d = ST_NUM;
      ST_NUM:       state_d = ST_ACC_START;
      ST_ACC_START: state_d = (inertia_q == '0) ? ST_SUM : ST_DIV_ACC;
      ST_DIV_ACC: begin
        if (div_done) begin
          state_d = ST_SUM;
        end
      end
      ST_SUM:       state_d = ST_DIV_DLT;
      ST_DIV_DLT: begin
        if (div_done) begin
          state_d = ST_STEP;
        end
      end
      ST_STEP:      state_d = ST_CLAMP;
      ST_CLAMP:     state_d = ST_OUT;
      ST_OUT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default:      state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o   = 1'b1;
    mul_start    = 1'b0;
    div_start    = 1'b0;
    div_dividend = {num_mag, {F{1'b0}}};
    div_divisor  = DvW'(inertia_q);
    div_steps    = StW'(DW);
    unique case (state_q)
      ST_IDLE: in_stall_o = 1'b0;
      ST_PREP: mul_start  = 1'b1;
      ST_ACC_START: begin
        div_start = (inertia_q != '0);
      end
      ST_SUM: begin
        // divide by twice the sample rate, MSB-aligned dividend
        div_start    = 1'b1;
        div_dividend = {sum_mag, {(DW-W-1){1'b0}}};
        div_divisor  = DvW'({rate_eff, 1'b0});
        div_steps    = StW'(W + 1);
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // arithmetic units
  // --------------------------------------------------------------------------
  via_serial_mul #(
    .AW (MAW),
    .BW (W)
  ) u_mul_damp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (mul_start),
    .a_i       (dmp_a),
    .b_i       (damping_q),
    .done_o    (dmp_done),
    .product_o (dmp_prod)
  );

  via_serial_mul #(
    .AW (MAW),
    .BW (W)
  ) u_mul_spring (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (mul_start),
    .a_i       (spr_a),
    .b_i       (spring_q),
    .done_o    (spr_done),
    .product_o (spr_prod)
  );

  via_serial_div #(
    .DW (DW),
    .VW (DvW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .steps_i    (div_steps),
    .done_o     (div_done),
    .quotient_o (div_q)
  );

  // --------------------------------------------------------------------------
  // datapath registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      force_q <= applied_force_i;
      vel_q   <= measured_velocity_i;
      pos_q   <= position_i;
    end
    if (state_q == ST_SCALE) begin
      dmp_q <= sat_ext(dmp_ext);
      spr_q <= sat_ext(spr_ext);
    end
    if (state_q == ST_NUM) begin
      num_q <= sat_w2(num_sum);
    end
    if (state_q == ST_ACC_START && inertia_q == '0) begin
      if (num_q == '0) begin
        accel_q <= '0;
      end else begin
        accel_q <= num_q[W-1] ? SMin : SMax;
      end
    end
    if (state_q == ST_DIV_ACC && div_done) begin
      // truncate toward zero on the magnitude, then restore the sign
      if (!num_q[W-1]) begin
        accel_q <= (div_q > DW'($unsigned(SMax))) ? SMax : $signed(div_q[W-1:0]);
      end else begin
        accel_q <= (div_q > DW'($unsigned(SMin))) ? SMin : -$signed(div_q[W-1:0]);
      end
    end
    if (state_q == ST_SUM) begin
      sum_neg_q <= sum_s[W];
    end
    if (state_q == ST_DIV_DLT && div_done) begin
      delta_q <= sum_neg_q ? -$signed(dq_mag) : $signed(dq_mag);
    end
    if (state_q == ST_STEP) begin
      vsat_q <= sat_w2(vsum);
    end
  end

  // sample state and the pending result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vacc_q    <= '0;
      prev_q    <= '0;
      res_vel_q <= '0;
      res_lim_q <= 1'b0;
    end else if (state_q == ST_IDLE && in_accept && cmd_i) begin
      vacc_q    <= '0;
      prev_q    <= '0;
      res_vel_q <= '0;
      res_lim_q <= 1'b0;
    end else if (state_q == ST_CLAMP) begin
      prev_q <= accel_q;
      priority if (vsat_q > lim_s) begin
        vacc_q    <= lim_s;
        res_vel_q <= lim_s;
        res_lim_q <= 1'b1;
      end else if (vsat_q < neg_lim) begin
        vacc_q    <= neg_lim;
        res_vel_q <= neg_lim;
        res_lim_q <= 1'b1;
      end else begin
        vacc_q    <= vsat_q;
        res_vel_q <= vsat_q;
        res_lim_q <= 1'b0;
      end
    end
  end

  // output register: hold while stalled, load when the slot frees up
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_OUT && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_OUT && out_free) begin
      out_vel_q <= res_vel_q;
      out_lim_q <= res_lim_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign virtual_velocity_o = out_vel_q;
  assign limited_o          = out_lim_q;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_out_in_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (virtual_velocity_o <= lim_s) && (virtual_velocity_o >= neg_lim))
    else $error("output velocity outside the velocity limit");

  a_limited_at_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && limited_o) |->
      ((virtual_velocity_o == lim_s) || (virtual_velocity_o == neg_lim)))
    else $error("limited flag set but velocity not at the limit");

  a_div_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> ((state_q == ST_DIV_ACC) || (state_q == ST_DIV_DLT)))
    else $error("divider finished outside a divide wait state");

  a_clear_zeroes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && cmd_i) |=> ((state_q == ST_OUT) && (vacc_q == '0) && (prev_q == '0)))
    else $error("clear command did not zero the state");

  a_mul_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dmp_done |-> (spr_done && (state_q == ST_MUL)))
    else $error("multipliers out of step");

endmodule
